[hw/rtl/awsb_pkg.sv]
// Package for the work-split balancer: constants, types and small helper functions.
package awsb_pkg;

   localparam int DIV_W  = 52;
   localparam int DVSR_W = 33;
   localparam int CNT_W  = $clog2(DIV_W);

   localparam logic [19:0] MAX_SPLIT_ROWS = 20'd131072;
   localparam logic [19:0] MIN_SPLIT_ROWS = 20'd4096;
   localparam logic signed [19:0] HOLD_BAND = 20'sd1024;
   localparam logic [20:0] DEFAULT_CUT  = 21'd65536;
   localparam logic [21:0] BUMP_DEFAULT = 22'd4096;
   localparam logic [15:0] FRAC_LOW  = 16'd13107;
   localparam logic [15:0] FRAC_HIGH = 16'd55706;

   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_SPLIT   = 2'd1;
   localparam logic [1:0] ACT_SINGLE  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_RATE_B, ST_RATE_B_WAIT, ST_RATE_A, ST_RATE_A_WAIT,
      ST_WALL, ST_EST, ST_EST_MUL, ST_EST_WAIT, ST_JUDGE, ST_FRAC_WAIT, ST_CUT,
      ST_SEED_WAIT, ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [31:0] sat32(input logic [DIV_W-1:0] q);
      return (q[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   // (sample + 3*old + 2) >> 2
   function automatic logic [31:0] ema32(input logic [31:0] s, input logic [31:0] o);
      logic [33:0] t;
      t = {2'b0, s} + {1'b0, o, 1'b0} + {2'b0, o} + 34'd2;
      return t[33:2];
   endfunction

endpackage

[hw/rtl/awsb_divider.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module awsb_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  awsb_pkg::div_ctrl_type         ctrl,
   input  logic [awsb_pkg::DIV_W-1:0]     dividend,
   input  logic [awsb_pkg::DVSR_W-1:0]    divisor,
   output awsb_pkg::div_stat_type         stat,
   output logic [awsb_pkg::DIV_W-1:0]     quotient
);

   logic [awsb_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [awsb_pkg::DVSR_W-1:0] rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [awsb_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [awsb_pkg::DVSR_W:0]   trial, diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[awsb_pkg::DIV_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep the difference if it fits
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = diff[awsb_pkg::DVSR_W-1:0];
            quo_in = {quo_ff[awsb_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[awsb_pkg::DVSR_W-1:0];
            quo_in = {quo_ff[awsb_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == awsb_pkg::CNT_W'(awsb_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

[hw/rtl/adaptive_work_split_balancer.sv]
// Top level of the work-split balancer: sequencer, state and result register.
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid/req_ready  | action, vocab, rows, times, wall time
//   rsp_    | out       | rsp_valid/rsp_ready  | cut, use_split, profitable, bail, estimate, join
//   csr_    | in        | csr_valid/csr_ready  | cut_override (20 bit)
//
// One word at a time. Every division runs on the shared bit-serial divider: a request
// uses at most one (the rate division), a split report up to three, a single-engine
// report at most one (the seed division), others none.
// Reset is synchronous and active high and clears the control and balancer state; data registers are not reset.
// A finished result waits in the output register; a new word is taken as soon as
// the result is loaded there, and only the next result waits for the sink.
module adaptive_work_split_balancer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [19:0] req_vocab_size,
   input  logic [19:0] req_gpu_rows,
   input  logic [31:0] req_gpu_time,
   input  logic [19:0] req_cpu_rows,
   input  logic [31:0] req_cpu_time,
   input  logic [31:0] req_wall_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [17:0] rsp_cut,
   output logic        rsp_use_split,
   output logic        rsp_profitable,
   output logic        rsp_bail_latched,
   output logic [31:0] rsp_single_estimate,
   output logic [31:0] rsp_join_time,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data
);

   awsb_pkg::state_type state_ff, state_in;

   // latched input word
   logic [1:0]  act_ff, act_in;
   logic [19:0] vocab_ff, vocab_in, rows_b_ff, rows_b_in, rows_a_ff, rows_a_in;
   logic [31:0] time_b_ff, time_b_in, time_a_ff, time_a_in, wall_ff, wall_in;

   // balancer state
   logic [19:0] ovr_ff;
   logic [31:0] rate_a_ff, rate_a_in, rate_b_ff, rate_b_in;
   logic [39:0] wall_avg_ff, wall_avg_in;
   logic        avg_valid_ff, avg_valid_in;
   logic [31:0] last_a_ff, last_a_in, last_b_ff, last_b_in;
   logic [17:0] held_ff, held_in;
   logic        bail_ff, bail_in;

   // working registers
   logic [20:0] base_ff, base_in;
   logic [51:0] prod_ff, prod_in;
   logic [17:0] cut_res_ff, cut_res_in;
   logic        use_res_ff, use_res_in, prof_res_ff, prof_res_in;
   logic [31:0] est_ff, est_in, join_ff, join_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [17:0] rsp_cut_ff, rsp_cut_in;
   logic        rsp_use_ff, rsp_use_in, rsp_prof_ff, rsp_prof_in, rsp_bail_ff, rsp_bail_in;
   logic [31:0] rsp_est_ff, rsp_est_in, rsp_join_ff, rsp_join_in;

   // divider
   awsb_pkg::div_ctrl_type div_ctrl;
   awsb_pkg::div_stat_type div_stat;
   logic [51:0] div_dividend, div_quot;
   logic [32:0] div_divisor;

   awsb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // combinational temporaries
   logic [31:0] r_sat, mx;
   logic [42:0] wsum;
   logic [39:0] wq;
   logic [40:0] wround;
   logic [31:0] rounded;
   logic [15:0] frac;
   logic [35:0] fprod;
   logic [36:0] fsum;
   logic [21:0] c, step;
   logic [32:0] a33, b33, aa, bb;
   logic [17:0] cut18;
   logic signed [19:0] d;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      vocab_in     = vocab_ff;
      rows_b_in    = rows_b_ff;
      rows_a_in    = rows_a_ff;
      time_b_in    = time_b_ff;
      time_a_in    = time_a_ff;
      wall_in      = wall_ff;
      rate_a_in    = rate_a_ff;
      rate_b_in    = rate_b_ff;
      wall_avg_in  = wall_avg_ff;
      avg_valid_in = avg_valid_ff;
      last_a_in    = last_a_ff;
      last_b_in    = last_b_ff;
      held_in      = held_ff;
      bail_in      = bail_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      cut_res_in   = cut_res_ff;
      use_res_in   = use_res_ff;
      prof_res_in  = prof_res_ff;
      est_in       = est_ff;
      join_in      = join_ff;
      rsp_cut_in   = rsp_cut_ff;
      rsp_use_in   = rsp_use_ff;
      rsp_prof_in  = rsp_prof_ff;
      rsp_bail_in  = rsp_bail_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_join_in  = rsp_join_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_ctrl.start = 1'b0;
      div_dividend   = '0;
      div_divisor    = '0;

      r_sat   = awsb_pkg::sat32(div_quot);
      mx      = (time_a_ff > time_b_ff) ? time_a_ff : time_b_ff;
      wq      = {wall_ff, 8'b0};
      wsum    = {3'b0, wq} + {2'b0, wall_avg_ff, 1'b0} + {3'b0, wall_avg_ff} + 43'd2;
      wround  = {1'b0, wall_avg_ff} + 41'd128;
      rounded = wround[39:8];

      // clamp the rate fraction and scale it to rows
      if (div_quot[16:0] < {1'b0, awsb_pkg::FRAC_LOW}) begin
         frac = awsb_pkg::FRAC_LOW;
      end else if (div_quot[16:0] > {1'b0, awsb_pkg::FRAC_HIGH}) begin
         frac = awsb_pkg::FRAC_HIGH;
      end else begin
         frac = div_quot[15:0];
      end
      fprod = frac * vocab_ff;
      fsum  = {1'b0, fprod} + 37'd32768;

      // bump by the last time imbalance, clamp, then hold within the band
      c    = {1'b0, base_ff};
      step = {7'b0, vocab_ff[19:13], 8'b0};
      a33  = {1'b0, last_a_ff};
      b33  = {1'b0, last_b_ff};
      aa   = a33 + (a33 >> 3);
      bb   = b33 + (b33 >> 3);
      if (last_a_ff != '0 && last_b_ff != '0) begin
         if (a33 > bb) begin
            c = c + ((step != '0) ? step : awsb_pkg::BUMP_DEFAULT);
         end else if (b33 > aa && c > step + {2'b0, awsb_pkg::MIN_SPLIT_ROWS}) begin
            c = c - step;
         end
      end
      if (c < {2'b0, awsb_pkg::MIN_SPLIT_ROWS}) c = {2'b0, awsb_pkg::MIN_SPLIT_ROWS};
      if (c > {2'b0, awsb_pkg::MAX_SPLIT_ROWS}) c = {2'b0, awsb_pkg::MAX_SPLIT_ROWS};
      if (c >= {2'b0, vocab_ff}) c = {3'b0, vocab_ff[19:1]};
      cut18 = c[17:0];
      d = $signed({2'b0, cut18}) - $signed({2'b0, held_ff});
      if (held_ff != '0 && d > -awsb_pkg::HOLD_BAND && d < awsb_pkg::HOLD_BAND) begin
         cut18 = held_ff;
      end

      case (state_ff)
         awsb_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in      = req_action;
               vocab_in    = req_vocab_size;
               rows_b_in   = req_gpu_rows;
               time_b_in   = req_gpu_time;
               rows_a_in   = req_cpu_rows;
               time_a_in   = req_cpu_time;
               wall_in     = req_wall_time;
               cut_res_in  = '0;
               use_res_in  = 1'b0;
               prof_res_in = 1'b0;
               est_in      = '0;
               join_in     = '0;
               state_in    = awsb_pkg::ST_DISPATCH;
            end
         end
         awsb_pkg::ST_DISPATCH: begin
            case (act_ff)
               awsb_pkg::ACT_REQUEST: begin
                  state_in = awsb_pkg::ST_OUTPUT;
                  if (!bail_ff && vocab_ff >= awsb_pkg::MIN_SPLIT_ROWS) begin
                     use_res_in = 1'b1;
                     if (ovr_ff >= awsb_pkg::MIN_SPLIT_ROWS && ovr_ff < vocab_ff) begin
                        // forced cut leaves the held cut alone
                        cut_res_in = (ovr_ff < awsb_pkg::MAX_SPLIT_ROWS) ? ovr_ff[17:0]
                                                                     : awsb_pkg::MAX_SPLIT_ROWS[17:0];
                     end else if (avg_valid_ff && rate_a_ff != '0 && rate_b_ff != '0) begin
                        div_ctrl.start = 1'b1;
                        div_dividend   = {4'b0, rate_b_ff, 16'b0};
                        div_divisor    = {1'b0, rate_a_ff} + {1'b0, rate_b_ff};
                        state_in       = awsb_pkg::ST_FRAC_WAIT;
                     end else begin
                        base_in  = awsb_pkg::DEFAULT_CUT;
                        state_in = awsb_pkg::ST_CUT;
                     end
                  end
               end
               awsb_pkg::ACT_SPLIT: begin
                  last_a_in = time_a_ff;
                  last_b_in = time_b_ff;
                  state_in  = awsb_pkg::ST_RATE_B;
               end
               awsb_pkg::ACT_SINGLE: begin
                  est_in   = time_a_ff;
                  state_in = awsb_pkg::ST_OUTPUT;
                  if (rate_a_ff == '0 && time_a_ff != '0 && vocab_ff != '0) begin
                     div_ctrl.start = 1'b1;
                     div_dividend   = {16'b0, vocab_ff, 16'b0};
                     div_divisor    = {1'b0, time_a_ff};
                     state_in       = awsb_pkg::ST_SEED_WAIT;
                  end
               end
               default: state_in = awsb_pkg::ST_OUTPUT;
            endcase
         end
         awsb_pkg::ST_RATE_B: begin
            if (time_b_ff != '0 && rows_b_ff != '0) begin
               div_ctrl.start = 1'b1;
               div_dividend   = {16'b0, rows_b_ff, 16'b0};
               div_divisor    = {1'b0, time_b_ff};
               state_in       = awsb_pkg::ST_RATE_B_WAIT;
            end else begin
               state_in = awsb_pkg::ST_RATE_A;
            end
         end
         awsb_pkg::ST_RATE_B_WAIT: begin
            if (div_stat.done) begin
               rate_b_in = avg_valid_ff ? awsb_pkg::ema32(r_sat, rate_b_ff) : r_sat;
               state_in  = awsb_pkg::ST_RATE_A;
            end
         end
         awsb_pkg::ST_RATE_A: begin
            if (time_a_ff != '0 && rows_a_ff != '0) begin
               div_ctrl.start = 1'b1;
               div_dividend   = {16'b0, rows_a_ff, 16'b0};
               div_divisor    = {1'b0, time_a_ff};
               state_in       = awsb_pkg::ST_RATE_A_WAIT;
            end else begin
               state_in = awsb_pkg::ST_WALL;
            end
         end
         awsb_pkg::ST_RATE_A_WAIT: begin
            if (div_stat.done) begin
               rate_a_in = avg_valid_ff ? awsb_pkg::ema32(r_sat, rate_a_ff) : r_sat;
               state_in  = awsb_pkg::ST_WALL;
            end
         end
         awsb_pkg::ST_WALL: begin
            wall_avg_in  = avg_valid_ff ? wsum[41:2] : wq;
            avg_valid_in = 1'b1;
            join_in      = (wall_ff > mx) ? wall_ff - mx : '0;
            state_in     = awsb_pkg::ST_EST;
         end
         awsb_pkg::ST_EST: begin
            if (rate_a_ff != '0) begin
               div_ctrl.start = 1'b1;
               div_dividend   = {16'b0, vocab_ff, 16'b0} + {21'b0, rate_a_ff[31:1]};
               div_divisor    = {1'b0, rate_a_ff};
               state_in       = awsb_pkg::ST_EST_WAIT;
            end else if (rows_a_ff != '0 && time_a_ff != '0) begin
               prod_in  = time_a_ff * vocab_ff;
               state_in = awsb_pkg::ST_EST_MUL;
            end else begin
               est_in   = '0;
               state_in = awsb_pkg::ST_JUDGE;
            end
         end
         awsb_pkg::ST_EST_MUL: begin
            div_ctrl.start = 1'b1;
            div_dividend   = prod_ff;
            div_divisor    = {13'b0, rows_a_ff};
            state_in       = awsb_pkg::ST_EST_WAIT;
         end
         awsb_pkg::ST_EST_WAIT: begin
            if (div_stat.done) begin
               est_in   = r_sat;
               state_in = awsb_pkg::ST_JUDGE;
            end
         end
         awsb_pkg::ST_JUDGE: begin
            // latch bail once the split stops paying off
            if (est_ff != '0) begin
               if (rounded < est_ff) prof_res_in = 1'b1;
               else bail_in = 1'b1;
            end
            state_in = awsb_pkg::ST_OUTPUT;
         end
         awsb_pkg::ST_FRAC_WAIT: begin
            if (div_stat.done) begin
               base_in  = fsum[36:16];
               state_in = awsb_pkg::ST_CUT;
            end
         end
         awsb_pkg::ST_CUT: begin
            held_in    = cut18;
            cut_res_in = cut18;
            state_in   = awsb_pkg::ST_OUTPUT;
         end
         awsb_pkg::ST_SEED_WAIT: begin
            if (div_stat.done) begin
               rate_a_in = r_sat;
               state_in  = awsb_pkg::ST_OUTPUT;
            end
         end
         awsb_pkg::ST_OUTPUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cut_in   = cut_res_ff;
               rsp_use_in   = use_res_ff;
               rsp_prof_in  = prof_res_ff;
               rsp_bail_in  = bail_ff;
               rsp_est_in   = est_ff;
               rsp_join_in  = join_ff;
               state_in     = awsb_pkg::ST_IDLE;
            end
         end
         default: state_in = awsb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      vocab_ff    <= vocab_in;
      rows_b_ff   <= rows_b_in;
      rows_a_ff   <= rows_a_in;
      time_b_ff   <= time_b_in;
      time_a_ff   <= time_a_in;
      wall_ff     <= wall_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      cut_res_ff  <= cut_res_in;
      use_res_ff  <= use_res_in;
      prof_res_ff <= prof_res_in;
      est_ff      <= est_in;
      join_ff     <= join_in;
      rsp_cut_ff  <= rsp_cut_in;
      rsp_use_ff  <= rsp_use_in;
      rsp_prof_ff <= rsp_prof_in;
      rsp_bail_ff <= rsp_bail_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_join_ff <= rsp_join_in;
      if (reset) begin
         state_ff     <= awsb_pkg::ST_IDLE;
         ovr_ff       <= '0;
         rate_a_ff    <= '0;
         rate_b_ff    <= '0;
         wall_avg_ff  <= '0;
         avg_valid_ff <= 1'b0;
         last_a_ff    <= '0;
         last_b_ff    <= '0;
         held_ff      <= '0;
         bail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid) ovr_ff <= csr_data;
         rate_a_ff    <= rate_a_in;
         rate_b_ff    <= rate_b_in;
         wall_avg_ff  <= wall_avg_in;
         avg_valid_ff <= avg_valid_in;
         last_a_ff    <= last_a_in;
         last_b_ff    <= last_b_in;
         held_ff      <= held_in;
         bail_ff      <= bail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready           = (state_ff == awsb_pkg::ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cut             = rsp_cut_ff;
   assign rsp_use_split       = rsp_use_ff;
   assign rsp_profitable      = rsp_prof_ff;
   assign rsp_bail_latched    = rsp_bail_ff;
   assign rsp_single_estimate = rsp_est_ff;
   assign rsp_join_time       = rsp_join_ff;

`ifndef SYNTH
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == awsb_pkg::ST_RATE_B_WAIT ||
                         state_ff == awsb_pkg::ST_RATE_A_WAIT ||
                         state_ff == awsb_pkg::ST_EST_WAIT ||
                         state_ff == awsb_pkg::ST_FRAC_WAIT ||
                         state_ff == awsb_pkg::ST_SEED_WAIT))
      else $error("divider finished outside a wait state");
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= awsb_pkg::MAX_SPLIT_ROWS[17:0])
      else $error("held cut above the split limit");
   a_bail_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(bail_ff)) |-> bail_ff)
      else $error("bail flag cleared without reset");
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider restarted while busy");
`endif

endmodule

[tb/adaptive_work_split_balancer_tb.sv]
// Self-checking testbench for the work-split balancer with a cycle-free predictor.
module adaptive_work_split_balancer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // Action code with no meaning: the block answers with zeros and the bail flag.
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [1:0]  action;
      logic [19:0] vocab;
      logic [19:0] rows_b;
      logic [31:0] time_b;
      logic [19:0] rows_a;
      logic [31:0] time_a;
      logic [31:0] wall;
   } run_word_type;

   typedef struct packed {
      logic [17:0] cut;
      logic        use_split;
      logic        profitable;
      logic        bail;
      logic [31:0] estimate;
      logic [31:0] join_time;
   } split_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   run_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [17:0] rsp_cut;
   logic rsp_use_split, rsp_profitable, rsp_bail_latched;
   logic [31:0] rsp_single_estimate, rsp_join_time;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [19:0] csr_data = '0;

   always #4 clock = ~clock;

   adaptive_work_split_balancer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_word.action),
      .req_vocab_size(req_word.vocab),
      .req_gpu_rows(req_word.rows_b),
      .req_gpu_time(req_word.time_b),
      .req_cpu_rows(req_word.rows_a),
      .req_cpu_time(req_word.time_a),
      .req_wall_time(req_word.wall),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cut(rsp_cut),
      .rsp_use_split(rsp_use_split),
      .rsp_profitable(rsp_profitable),
      .rsp_bail_latched(rsp_bail_latched),
      .rsp_single_estimate(rsp_single_estimate),
      .rsp_join_time(rsp_join_time),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   // Predictor copy of the block's state and its one register.
   logic [19:0] shadow_override;
   logic [31:0] avg_rate_a, avg_rate_b;
   logic [39:0] avg_wall;
   logic        avgs_loaded;
   logic [31:0] prev_time_a, prev_time_b;
   logic [17:0] sticky_cut;
   logic        bailed;

   run_word_type     pending_words[$];
   split_answer_type expected_answers[$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   function automatic logic [31:0] clip32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] rows_per_us(logic [63:0] rows, logic [63:0] us);
      if (us == 64'd0) return 32'd0;
      return clip32((rows << 16) / us);
   endfunction

   function automatic logic [31:0] blend_quarter(logic [31:0] sample, logic [31:0] old);
      logic [63:0] t;
      t = (64'(sample) + 64'd3 * 64'(old) + 64'd2) >> 2;
      return t[31:0];
   endfunction

   // Pick the B-engine share: override, else rate fraction or default cut, imbalance bump, clamp, then hold.
   function automatic logic [17:0] pick_cut(logic [19:0] vocab);
      logic [63:0] c, frac, step, ta, tb;
      longint d;
      c = 64'd65536;
      if (shadow_override >= awsb_pkg::MIN_SPLIT_ROWS && shadow_override < vocab)
         return (shadow_override < awsb_pkg::MAX_SPLIT_ROWS) ? 18'(shadow_override)
                                                             : 18'(awsb_pkg::MAX_SPLIT_ROWS);
      if (avgs_loaded && avg_rate_a != '0 && avg_rate_b != '0) begin
         frac = (64'(avg_rate_b) << 16) / (64'(avg_rate_a) + 64'(avg_rate_b));
         if (frac < 64'(awsb_pkg::FRAC_LOW)) frac = 64'(awsb_pkg::FRAC_LOW);
         if (frac > 64'(awsb_pkg::FRAC_HIGH)) frac = 64'(awsb_pkg::FRAC_HIGH);
         c = (frac * 64'(vocab) + 64'd32768) >> 16;
      end
      if (prev_time_a != '0 && prev_time_b != '0) begin
         ta = 64'(prev_time_a);
         tb = 64'(prev_time_b);
         step = (64'(vocab) >> 5) & ~64'd255;
         if (ta > tb + (tb >> 3))
            c = c + ((step != 64'd0) ? step : 64'(awsb_pkg::BUMP_DEFAULT));
         else if (tb > ta + (ta >> 3) && c > step + 64'(awsb_pkg::MIN_SPLIT_ROWS))
            c = c - step;
      end
      if (c < 64'(awsb_pkg::MIN_SPLIT_ROWS)) c = 64'(awsb_pkg::MIN_SPLIT_ROWS);
      if (c > 64'(awsb_pkg::MAX_SPLIT_ROWS)) c = 64'(awsb_pkg::MAX_SPLIT_ROWS);
      if (c >= 64'(vocab)) c = 64'(vocab >> 1);
      if (sticky_cut != '0) begin
         d = longint'(c) - longint'(64'(sticky_cut));
         if (d > -64'sd1024 && d < 64'sd1024) c = 64'(sticky_cut);
      end
      sticky_cut = c[17:0];
      return c[17:0];
   endfunction

   function automatic split_answer_type balance_word(run_word_type w);
      split_answer_type a;
      logic [63:0] est, wq;
      logic [31:0] longest, rounded;
      a = '0;
      case (w.action)
         awsb_pkg::ACT_REQUEST: begin
            if (!bailed && w.vocab >= awsb_pkg::MIN_SPLIT_ROWS) begin
               a.use_split = 1'b1;
               a.cut = pick_cut(w.vocab);
            end
         end
         awsb_pkg::ACT_SPLIT: begin
            wq = 64'(w.wall) << 8;
            prev_time_b = w.time_b;
            prev_time_a = w.time_a;
            if (w.time_b != '0 && w.rows_b != '0)
               avg_rate_b = avgs_loaded
                  ? blend_quarter(rows_per_us(64'(w.rows_b), 64'(w.time_b)), avg_rate_b)
                  : rows_per_us(64'(w.rows_b), 64'(w.time_b));
            if (w.time_a != '0 && w.rows_a != '0)
               avg_rate_a = avgs_loaded
                  ? blend_quarter(rows_per_us(64'(w.rows_a), 64'(w.time_a)), avg_rate_a)
                  : rows_per_us(64'(w.rows_a), 64'(w.time_a));
            avg_wall = avgs_loaded ? 40'((wq + 64'd3 * 64'(avg_wall) + 64'd2) >> 2) : wq[39:0];
            avgs_loaded = 1'b1;
            longest = (w.time_a > w.time_b) ? w.time_a : w.time_b;
            a.join_time = (w.wall > longest) ? w.wall - longest : 32'd0;
            est = '0;
            if (avg_rate_a != '0)
               est = 64'(clip32(((64'(w.vocab) << 16) + 64'(avg_rate_a >> 1))
                                / 64'(avg_rate_a)));
            else if (w.rows_a != '0 && w.time_a != '0)
               est = 64'(clip32((64'(w.time_a) * 64'(w.vocab)) / 64'(w.rows_a)));
            a.estimate = est[31:0];
            rounded = 32'((64'(avg_wall) + 64'd128) >> 8);
            if (est != '0) begin
               if (rounded < est[31:0]) a.profitable = 1'b1;
               else bailed = 1'b1;
            end
         end
         awsb_pkg::ACT_SINGLE: begin
            a.estimate = w.time_a;
            if (avg_rate_a == '0 && w.time_a != '0 && w.vocab != '0)
               avg_rate_a = rows_per_us(64'(w.vocab), 64'(w.time_a));
         end
         default: ;
      endcase
      a.bail = bailed;
      return a;
   endfunction

   // Driver: offer the next word once the current one is taken; predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_answers.push_back(balance_word(req_word));
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_word <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result word, drive ready, run the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word: cut=%0d est=%0d",
                                             rsp_cut, rsp_single_estimate);
            end else begin
               split_answer_type e;
               e = expected_answers.pop_front();
               if (rsp_cut !== e.cut || rsp_use_split !== e.use_split
                   || rsp_profitable !== e.profitable || rsp_bail_latched !== e.bail
                   || rsp_single_estimate !== e.estimate || rsp_join_time !== e.join_time) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp cut=%0d use=%b prof=%b bail=%b est=%0d join=%0d",
                               " / got cut=%0d use=%b prof=%b bail=%b est=%0d join=%0d"},
                              e.cut, e.use_split, e.profitable, e.bail, e.estimate,
                              e.join_time, rsp_cut, rsp_use_split, rsp_profitable,
                              rsp_bail_latched, rsp_single_estimate, rsp_join_time);
               end
            end
         end
         // Hold off the sink for a long stretch when asked, so the block backs up.
         if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic run_word_type make_word(logic [1:0] act, logic [19:0] vocab,
                                              logic [19:0] rb, logic [31:0] tb,
                                              logic [19:0] ra, logic [31:0] ta,
                                              logic [31:0] wall);
      run_word_type w;
      w.action = act;
      w.vocab = vocab;
      w.rows_b = rb;
      w.time_b = tb;
      w.rows_a = ra;
      w.time_a = ta;
      w.wall = wall;
      return w;
   endfunction

   // Plausible split run: B takes half or more of the rows, each engine with a random time per row.
   function automatic run_word_type sane_report(logic [19:0] vocab);
      logic [19:0] rb, ra;
      rb = (vocab >> 1) + 20'($urandom_range(32'(vocab >> 3)));
      ra = vocab - rb;
      return make_word(awsb_pkg::ACT_SPLIT, vocab, rb,
                       32'(rb) * 32'($urandom_range(5, 1)), ra,
                       32'(ra) * 32'($urandom_range(4, 2)),
                       32'($urandom_range(32'(vocab), 1)));
   endfunction

   function automatic run_word_type noise_word();
      return make_word(2'($urandom_range(3)), 20'($urandom), 20'($urandom), $urandom,
                       20'($urandom), $urandom, $urandom);
   endfunction

   task automatic settle();
      wait (pending_words.size() == 0 && !req_valid && expected_answers.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_override(logic [19:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      shadow_override = v;
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count, logic [19:0] vocab);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 48)
            pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST,
                                              vocab + 20'($urandom_range(64)),
                                              20'($urandom), $urandom, 20'($urandom),
                                              $urandom, $urandom));
         else if (pick < 88)
            pending_words.push_back(sane_report(vocab));
         else if (pick < 93)
            pending_words.push_back(make_word(awsb_pkg::ACT_SINGLE, 20'($urandom),
                                              20'($urandom), $urandom,
                                              20'($urandom), $urandom, $urandom));
         else if (pick < 96)
            pending_words.push_back(make_word(ACT_UNUSED, 20'($urandom),
                                              20'($urandom), $urandom,
                                              20'($urandom), $urandom, $urandom));
         else
            pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'($urandom),
                                              '0, '0, '0, '0, '0));
      end
   endtask

   initial begin
      logic [19:0] overrides[5];
      shadow_override = '0;
      avg_rate_a = '0;
      avg_rate_b = '0;
      avg_wall = '0;
      avgs_loaded = 1'b0;
      prev_time_a = '0;
      prev_time_b = '0;
      sticky_cut = '0;
      bailed = 1'b0;
      overrides = '{20'd0, 20'd5000, 20'hFFFFF, 20'd4096, 20'd200000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: small and large vocab, seeding, undefined action, imbalance both ways.
      write_override(20'd0);
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd0, '0, '0, '0, '0, '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd4095, '0, '0, '0, '0, '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd4096, '0, '0, '0, '0, '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'hFFFFF, '0, '0, '0, '0, '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd100000, '0, '0, '0, '0,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_SINGLE, 20'd0, '0, '0, '0, 32'd5000,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_SINGLE, 20'd100000, '0, '0, '0, 32'd0,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_SINGLE, 20'd100000, '0, '0, '0,
                                        32'd250000, '0));
      pending_words.push_back(make_word(ACT_UNUSED, 20'hFFFFF, 20'hFFFFF, '1, 20'hFFFFF, '1,
                                        '1));
      pending_words.push_back(make_word(awsb_pkg::ACT_SPLIT, 20'd100000, '0, '0, '0, '0, '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd100000, '0, '0, '0, '0,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_SPLIT, 20'd100000, 20'd60000, 32'd60000,
                                        20'd40000, 32'd100000, 32'd1000));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd100000, '0, '0, '0, '0,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd100500, '0, '0, '0, '0,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_SPLIT, 20'd100000, 20'd60000,
                                        32'd200000, 20'd40000, 32'd100000, 32'd2000));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd100000, '0, '0, '0, '0,
                                        '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_SPLIT, 20'd100000, 20'd0, 32'd9000,
                                        20'd40000, 32'd0, 32'd500));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd8000, '0, '0, '0, '0, '0));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd200000, '0, '0, '0, '0,
                                        '0));
      settle();

      // Random phases: walk the idle patterns and override settings.
      for (int p = 0; p < 5; p++) begin
         write_override(overrides[p]);
         send_idle_pct = (p % 4 == 1) ? 47 : (p % 4 == 3) ? 34 : 0;
         recv_stall_pct = (p % 4 == 2) ? 47 : (p % 4 == 3) ? 34 : 0;
         if (p == 2) hold_requests++;
         random_phase(190, 20'($urandom_range(300000, 8192)));
         settle();
      end

      // Force the bail, then full-range noise on every field.
      send_idle_pct = 20;
      recv_stall_pct = 20;
      pending_words.push_back(make_word(awsb_pkg::ACT_SPLIT, 20'd100000, 20'd50000, 32'd1000,
                                        20'd50000, 32'd1000, '1));
      pending_words.push_back(make_word(awsb_pkg::ACT_REQUEST, 20'd100000, '0, '0, '0, '0,
                                        '0));
      for (int i = 0; i < 80; i++) pending_words.push_back(noise_word());
      settle();
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
